// ----- src/ils_pkg.sv -----
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes for the integer literal scanner: radix codes, result
// status codes, the operation passed from front to back, and queue sizing.
// ----------------------------------------------------------------------------
package ils_pkg;

	localparam int VALUE_BITS_DEF = 31;

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [1:0] radix_t;
	localparam radix_t RX_DEC = 2'd0;
	localparam radix_t RX_OCT = 2'd1;
	localparam radix_t RX_HEX = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_OVF   = 2'd1;
	localparam status_t ST_RANGE = 2'd2;
	localparam status_t ST_EMPTY = 2'd3;

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_NOP   = 2'd0;
	localparam opcode_t OP_DIGIT = 2'd1;
	localparam opcode_t OP_BAD   = 2'd2;
	localparam opcode_t OP_TERM  = 2'd3;

	typedef struct packed {
		opcode_t    op;
		logic [3:0] digit;
		radix_t     radix;
		logic       empty;
	} ils_op_t;

endpackage

// ----- src/ils_front.sv -----
// ----------------------------------------------------------------------------
// ils_front
// Character classifier: tracks the literal prefix, picks the radix and turns
// each accepted character into a digit, bad-digit, no-op or terminator op.
// ----------------------------------------------------------------------------
module ils_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      char_in,
	output ils_pkg::ils_op_t op
);
	import ils_pkg::*;

	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_ZERO   = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;
	localparam logic [1:0] PH_HEXPFX = 2'd3;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_7   = 8'h37;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_UX  = 8'h58;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LF  = 8'h66;
	localparam logic [7:0] CH_LX  = 8'h78;

	logic [1:0] phase_q, phase_d;
	radix_t     radix_q, radix_d;

	// {is_digit, digit value}
	function automatic logic [4:0] classify(input logic [7:0] c, input radix_t rx);
		logic [7:0] t;
		begin
			t = 8'd0;
			classify = 5'd0;
			if (rx == RX_OCT) begin
				if (c >= CH_0 && c <= CH_7) begin
					t = c - CH_0;
					classify = {1'b1, t[3:0]};
				end
			end else if (c >= CH_0 && c <= CH_9) begin
				t = c - CH_0;
				classify = {1'b1, t[3:0]};
			end else if (rx == RX_HEX && c >= CH_LA && c <= CH_LF) begin
				t = c - CH_LA + 8'd10;
				classify = {1'b1, t[3:0]};
			end else if (rx == RX_HEX && c >= CH_UA && c <= CH_UF) begin
				t = c - CH_UA + 8'd10;
				classify = {1'b1, t[3:0]};
			end
		end
	endfunction

	logic [4:0] cls;
	radix_t     use_rx;
	logic       is_nop;

	always_comb begin
		phase_d = phase_q;
		radix_d = radix_q;
		use_rx  = radix_q;
		is_nop  = 1'b0;
		op      = '0;
		if (char_in == CH_NUL) begin
			phase_d = PH_START;
			radix_d = RX_DEC;
		end else begin
			unique case (phase_q)
				PH_START: begin
					if (char_in == CH_0) begin
						phase_d = PH_ZERO;
						radix_d = RX_OCT;
						is_nop  = 1'b1;
					end else begin
						phase_d = PH_BODY;
						radix_d = RX_DEC;
						use_rx  = RX_DEC;
					end
				end
				PH_ZERO: begin
					if (char_in == CH_LX || char_in == CH_UX) begin
						phase_d = PH_HEXPFX;
						radix_d = RX_HEX;
						is_nop  = 1'b1;
					end else begin
						phase_d = PH_BODY;
					end
				end
				default: phase_d = PH_BODY;
			endcase
		end
		cls = classify(char_in, use_rx);
		op.radix = use_rx;
		op.digit = cls[3:0];
		op.empty = (phase_q == PH_START) || (phase_q == PH_HEXPFX);
		priority if (char_in == CH_NUL) op.op = OP_TERM;
		else if (is_nop)                op.op = OP_NOP;
		else if (cls[4])                op.op = OP_DIGIT;
		else                            op.op = OP_BAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			radix_q <= RX_DEC;
		end else if (take) begin
			phase_q <= phase_d;
			radix_q <= radix_d;
		end
	end

endmodule

// ----- src/ils_queue.sv -----
// ----------------------------------------------------------------------------
// ils_queue
// Short first-in first-out queue of classified ops between front and back.
// ----------------------------------------------------------------------------
module ils_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ils_pkg::ils_op_t push_data,
	output logic             full,
	input  logic             pop,
	output ils_pkg::ils_op_t pop_data,
	output logic             nonempty
);
	import ils_pkg::*;

	ils_op_t             entries_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			priority if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push)     count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- src/ils_back.sv -----
// ----------------------------------------------------------------------------
// ils_back
// Accumulator and error tracking: applies ops from the queue, detects
// overflow and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module ils_back #(
	parameter int VALUE_BITS = ils_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  nonempty,
	input  ils_pkg::ils_op_t      op,
	output logic                  pop,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [VALUE_BITS-1:0] value,
	output logic [1:0]            status
);
	import ils_pkg::*;

	localparam int WW = VALUE_BITS + 4;

	logic [VALUE_BITS-1:0] acc_q;
	status_t               err_q;
	logic                  res_valid_q;
	logic [VALUE_BITS-1:0] res_value_q;
	status_t               res_status_q;

	logic [WW-1:0] acc_w, scaled, next_w;
	logic          ovf;
	logic          out_busy;

	assign out_busy = res_valid_q && result_stall;
	// only a terminator needs the output register
	assign pop = nonempty && !(op.op == OP_TERM && out_busy);

	always_comb begin
		acc_w = {4'b0, acc_q};
		unique case (op.radix)
			RX_HEX:  scaled = acc_w << 4;
			RX_OCT:  scaled = acc_w << 3;
			default: scaled = (acc_w << 3) + (acc_w << 1);
		endcase
		next_w = scaled + {{(WW - 4){1'b0}}, op.digit};
		ovf    = |next_w[WW-1:VALUE_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			err_q       <= ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !result_stall) res_valid_q <= 1'b0;
			if (pop) begin
				unique case (op.op)
					OP_TERM: begin
						res_valid_q <= 1'b1;
						acc_q       <= '0;
						err_q       <= ST_OK;
					end
					OP_DIGIT: begin
						if (err_q == ST_OK) begin
							if (ovf) err_q <= ST_OVF;
							else     acc_q <= next_w[VALUE_BITS-1:0];
						end
					end
					OP_BAD: begin
						if (err_q == ST_OK) err_q <= ST_RANGE;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && op.op == OP_TERM) begin
			priority if (err_q != ST_OK) begin
				res_status_q <= err_q;
				res_value_q  <= '0;
			end else if (op.empty) begin
				res_status_q <= ST_EMPTY;
				res_value_q  <= '0;
			end else begin
				res_status_q <= ST_OK;
				res_value_q  <= acc_q;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign value        = res_value_q;
	assign status       = res_status_q;

endmodule

// ----- src/integer_literal_scanner.sv -----
// ----------------------------------------------------------------------------
// integer_literal_scanner
// Scans an unsigned C-style integer literal (decimal, octal, hexadecimal)
// arriving one character per transfer and reports its value and status.
// ----------------------------------------------------------------------------
// Usage:
//  - char channel: one byte per transfer (char_valid high, char_stall low).
//    A zero byte ends the literal; every other byte produces no result.
//  - result channel: one transfer per terminator, carrying value and status
//    (0 scanned, 1 overflow, 2 digit out of range, 3 empty). value is zero
//    whenever status is not 0.
//  - throughput: one character per cycle while char_stall is low. The front
//    classifier and the back accumulator each handle one item a cycle, save
//    a terminator held while the output register is busy; a two-entry queue
//    sits between them. A terminator passes through the queue to the back,
//    which registers its result in the output register.
//  - when the receiver stalls, the result holds in the output register while
//    digits keep flowing into the accumulator; a second terminator waits in
//    the queue, and char_stall rises once the queue is full.
//  - reset clears the prefix state, the queue, the accumulator and any
//    pending result; the next byte starts a new literal.
// ----------------------------------------------------------------------------
module integer_literal_scanner #(
	parameter int VALUE_BITS = ils_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  logic [7:0]            char_in,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [VALUE_BITS-1:0] value,
	output logic [1:0]            status
);
	import ils_pkg::*;

	ils_op_t front_op, queue_op;
	logic    take, q_full, q_pop, q_nonempty;

	assign take       = char_valid && !q_full;
	assign char_stall = q_full;

	ils_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.char_in (char_in),
		.op      (front_op)
	);

	ils_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (front_op),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (queue_op),
		.nonempty  (q_nonempty)
	);

	ils_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.nonempty     (q_nonempty),
		.op           (queue_op),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.status       (status)
	);

endmodule

// ----- src/ils_checker.sv -----
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks for the integer literal scanner, bound to the top level.
// ----------------------------------------------------------------------------
module ils_checker #(
	parameter int VALUE_BITS = ils_pkg::VALUE_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  char_valid,
	input logic                  char_stall,
	input logic [7:0]            char_in,
	input logic                  result_valid,
	input logic                  result_stall,
	input logic [VALUE_BITS-1:0] value,
	input logic [1:0]            status
);
	import ils_pkg::*;

	// a failed or empty literal never reports a value
	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_OK |-> value == '0)
		else $error("nonzero value with error status");

	// the queue only fills through an input transfer
	a_stall_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(char_stall) |-> $past(char_valid && !char_stall))
		else $error("char_stall rose without a transfer");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("stalled result dropped");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(value) && $stable(status))
		else $error("stalled result changed");

endmodule

bind integer_literal_scanner ils_checker #(.VALUE_BITS(VALUE_BITS)) u_ils_checker (.*);
